// ===== hdl/i2cbb_pkg.sv =====
`timescale 1ns / 1ps

package i2cbb_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int PHASE_W   = 16;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd16;

    // Sequence codes, equal to the request codes that start them.
    localparam logic [2:0] SEQ_IDLE  = 3'd0;
    localparam logic [2:0] SEQ_START = 3'd1;
    localparam logic [2:0] SEQ_STOP  = 3'd2;
    localparam logic [2:0] SEQ_WRITE = 3'd3;
    localparam logic [2:0] SEQ_READ  = 3'd4;

    localparam logic [3:0] STEP_END      = 4'd15;
    localparam logic [3:0] BITS_PER_BYTE = 4'h8;

    typedef struct packed {
        logic       sda_in;
        logic       release_ack;
        logic [7:0] write_byte;
        logic [2:0] req_type;
    } in_item_t;

    typedef struct packed {
        logic       read_done;
        logic [7:0] read_byte;
        logic       busy_res;
        logic       sda_low;
        logic       scl_low;
    } out_item_t;

endpackage

// ===== hdl/i2c_bit_bang_master_unit.sv =====
`timescale 1ns / 1ps
// Output: the result for a tick is registered and is on m_tdata in the cycle after its input transfer.
// Throughput: one tick per clock cycle; a new tick is taken whenever the output
// register is empty or is being read in the same cycle.
// Reset: synchronous on aresetn low; the sequencer goes idle with both lines
// released, read_byte clears, the output register empties and phase_ticks returns to 16.
module i2c_bit_bang_master_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [i2cbb_pkg::PHASE_W-1:0]    cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // req_type[2:0], write_byte[10:3], release_ack[11], sda_in[12], zero[15:13]
    input  logic [i2cbb_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // scl_low[0], sda_low[1], busy_res[2], read_byte[10:3], read_done[11], zero[15:12]
    output logic [i2cbb_pkg::M_TDATA_W-1:0]  m_tdata
);
    import i2cbb_pkg::*;

    logic [PHASE_W-1:0] phase_ticks_reg;
    logic [2:0]         seq_reg, seq_next;
    logic [3:0]         step_reg, step_next;
    logic [3:0]         bitc_reg, bitc_next;
    logic [7:0]         shift_reg, shift_next;
    logic [PHASE_W-1:0] tick_reg, tick_next;
    logic [1:0]         units_reg, units_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               ack_reg, ack_next;
    logic [7:0]         rx_reg, rx_next;
    logic               done_next;
    logic               m_tvalid_reg;
    out_item_t          m_item_reg;
    in_item_t           in_item;
    logic               accept;

    assign in_item  = in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-$bits(out_item_t)){1'b0}}, m_item_reg};

    always_comb begin
        logic [PHASE_W-1:0] p;
        logic [3:0]         nx;
        logic               enter;
        logic [1:0]         units_m1;

        p         = (phase_ticks_reg == '0) ? PHASE_W'(1) : phase_ticks_reg;
        nx        = STEP_END;
        enter     = 1'b0;
        units_m1  = 2'd0;
        seq_next  = seq_reg;
        step_next = step_reg;
        bitc_next = bitc_reg;
        shift_next = shift_reg;
        tick_next = tick_reg;
        units_next = units_reg;
        scl_next  = scl_reg;
        sda_next  = sda_reg;
        ack_next  = ack_reg;
        rx_next   = rx_reg;
        done_next = 1'b0;

        // Advance the running segment or pick the next one.
        if (seq_reg != SEQ_IDLE) begin
            if (tick_reg != '0) begin
                tick_next = tick_reg - PHASE_W'(1);
            end else if (units_reg != 2'd0) begin
                units_next = units_reg - 2'd1;
                tick_next  = p - PHASE_W'(1);
            end else begin
                if (seq_reg == SEQ_START || seq_reg == SEQ_STOP) begin
                    nx = (step_reg == 4'd0) ? 4'd1 : STEP_END;
                end else if (seq_reg == SEQ_WRITE || seq_reg == SEQ_READ) begin
                    case (step_reg)
                        4'd0, 4'd1, 4'd4, 4'd6, 4'd7, 4'd8: begin
                            nx = step_reg + 4'd1;
                        end
                        4'd2: begin
                            bitc_next = bitc_reg + 4'd1;
                            nx = (bitc_next < BITS_PER_BYTE) ? 4'd0 : 4'd3;
                        end
                        4'd3: begin
                            nx = (seq_reg == SEQ_WRITE || ack_reg) ? 4'd4 : 4'd6;
                        end
                        default: begin
                            nx = STEP_END;
                        end
                    endcase
                end
                if (nx == STEP_END) begin
                    if (seq_reg == SEQ_STOP) begin
                        sda_next = 1'b0;
                    end
                    if (seq_reg == SEQ_READ) begin
                        rx_next   = shift_reg;
                        done_next = 1'b1;
                    end
                    seq_next  = SEQ_IDLE;
                    step_next = 4'd0;
                end else begin
                    step_next = nx;
                    enter     = 1'b1;
                end
            end
        end

        // A new command is taken only once the sequencer is idle.
        if (seq_next == SEQ_IDLE && in_item.req_type >= SEQ_START &&
            in_item.req_type <= SEQ_READ) begin
            seq_next  = in_item.req_type;
            step_next = 4'd0;
            bitc_next = 4'd0;
            if (in_item.req_type == SEQ_WRITE) begin
                shift_next = in_item.write_byte;
            end else if (in_item.req_type == SEQ_READ) begin
                shift_next = 8'd0;
            end
            ack_next = in_item.release_ack;
            enter    = 1'b1;
        end

        // Drive changes at the start of a segment, and its length.
        if (enter) begin
            if (seq_next == SEQ_START || seq_next == SEQ_STOP) begin
                units_m1 = 2'd1;
                if (step_next == 4'd0) begin
                    sda_next = 1'b1;
                end else begin
                    scl_next = (seq_next == SEQ_START);
                end
            end else if (seq_next == SEQ_WRITE || seq_next == SEQ_READ) begin
                case (step_next)
                    4'd0: begin
                        if (seq_next == SEQ_WRITE) begin
                            sda_next = !shift_next[7];
                        end
                    end
                    4'd1: begin
                        scl_next = 1'b0;
                        if (seq_next == SEQ_WRITE) begin
                            shift_next = {shift_next[6:0], 1'b0};
                        end else begin
                            shift_next = {shift_next[6:0], in_item.sda_in};
                        end
                    end
                    4'd2: scl_next = 1'b1;
                    4'd3: begin
                        if (seq_next == SEQ_WRITE) begin
                            sda_next = 1'b0;
                        end
                    end
                    4'd4: begin
                        scl_next = 1'b0;
                        units_m1 = 2'd3;
                    end
                    4'd5: begin
                        scl_next = 1'b1;
                        units_m1 = 2'd3;
                    end
                    4'd6: sda_next = 1'b1;
                    4'd7: begin
                        scl_next = 1'b0;
                        units_m1 = 2'd1;
                    end
                    4'd8: scl_next = 1'b1;
                    4'd9: begin
                        sda_next = 1'b0;
                        units_m1 = 2'd3;
                    end
                    default: units_m1 = 2'd0;
                endcase
            end
            tick_next  = p - PHASE_W'(1);
            units_next = units_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            seq_reg      <= SEQ_IDLE;
            step_reg     <= 4'd0;
            bitc_reg     <= 4'd0;
            shift_reg    <= 8'd0;
            tick_reg     <= '0;
            units_reg    <= 2'd0;
            scl_reg      <= 1'b0;
            sda_reg      <= 1'b0;
            ack_reg      <= 1'b0;
            rx_reg       <= 8'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                phase_ticks_reg <= cfg_wdata;
            end
            if (accept) begin
                seq_reg   <= seq_next;
                step_reg  <= step_next;
                bitc_reg  <= bitc_next;
                shift_reg <= shift_next;
                tick_reg  <= tick_next;
                units_reg <= units_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                ack_reg   <= ack_next;
                rx_reg    <= rx_next;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg.scl_low   <= scl_next;
            m_item_reg.sda_low   <= sda_next;
            m_item_reg.busy_res  <= (seq_next != SEQ_IDLE);
            m_item_reg.read_byte <= rx_next;
            m_item_reg.read_done <= done_next;
        end
    end

endmodule

// ===== hdl/i2cbb_checker.sv =====
`timescale 1ns / 1ps
module i2cbb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [i2cbb_pkg::M_TDATA_W-1:0]  m_tdata
);
    import i2cbb_pkg::*;

    // A held result keeps its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty output register never holds back the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // Every input transfer produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("input transfer without result");

    // Nothing comes out right after a reset cycle.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind i2c_bit_bang_master_unit i2cbb_checker u_i2cbb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
